/* hw/rtl/crcfr_pkg.sv */
// ----------------------------------------------------------------------------
// crcfr_pkg: shared types, constants and CRC function
// Constants, status codes and the CRC16/Modbus byte update for the
// framed packet receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package crcfr_pkg;

   localparam int unsigned IdxW   = 17;
   localparam int unsigned CsrIdxW = 1;

   localparam logic [IdxW-1:0] IDX_MAX   = {IdxW{1'b1}};
   localparam logic [IdxW-1:0] MIN_FRAME = IdxW'(8);

   // frame positions
   localparam logic [IdxW-1:0] POS_START   = IdxW'(0);
   localparam logic [IdxW-1:0] POS_SEQ     = IdxW'(1);
   localparam logic [IdxW-1:0] POS_CMD     = IdxW'(2);
   localparam logic [IdxW-1:0] POS_LEN_HI  = IdxW'(3);
   localparam logic [IdxW-1:0] POS_LEN_LO  = IdxW'(4);
   localparam logic [IdxW-1:0] POS_PAYLOAD = IdxW'(5);

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_START_BYTE = CsrIdxW'(0);
   localparam logic [CsrIdxW-1:0] CSR_END_BYTE   = CsrIdxW'(1);

   localparam logic [7:0] START_BYTE_RST = 8'hAA;
   localparam logic [7:0] END_BYTE_RST   = 8'h55;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_SHORT     = 3'd1;
   localparam logic [2:0] ST_BAD_START = 3'd2;
   localparam logic [2:0] ST_BAD_END   = 3'd3;
   localparam logic [2:0] ST_LEN_ERR   = 3'd4;
   localparam logic [2:0] ST_CRC_ERR   = 3'd5;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef struct packed {
      logic        is_summary;
      logic [7:0]  payload_byte;
      logic [2:0]  status;
      logic [7:0]  seq_number;
      logic [7:0]  command;
      logic [15:0] payload_length;
   } rsp_payload_type;

   // reflected CRC16/Modbus update for one byte
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/crcfr_if.sv */
// ----------------------------------------------------------------------------
// crcfr_if: channel interfaces
// Valid/ready channels for received bytes, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface crcfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       end_of_buffer;

   modport source (output valid, output rx_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

interface crcfr_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_summary;
   logic [7:0]  payload_byte;
   logic [2:0]  status;
   logic [7:0]  seq_number;
   logic [7:0]  command;
   logic [15:0] payload_length;

   modport source (output valid, output is_summary, output payload_byte, output status,
                   output seq_number, output command, output payload_length, input ready);
   modport sink   (input valid, input is_summary, input payload_byte, input status,
                   input seq_number, input command, input payload_length, output ready);
endinterface

interface crcfr_csr_if;
   logic                          valid;
   logic                          ready;
   logic [crcfr_pkg::CsrIdxW-1:0] index;
   logic [7:0]                    wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

/* hw/rtl/crc16_frame_receiver.sv */
// ----------------------------------------------------------------------------
// crc16_frame_receiver: framed packet receiver with CRC16/Modbus check
// Streams payload bytes out and reports one summary per received buffer.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch  - one received byte per item; end_of_buffer marks the last byte.
//   rsp_ch  - one payload byte item per payload byte (not on the last byte),
//             and one summary item (status, seq, command, length) on the
//             last byte of every buffer. Other bytes give no item.
//   csr_ch  - register writes: index 0 start byte, index 1 end byte.
//             Always ready; write only while the block is idle.
// Timing:
//   Two register stages: input stage, then result register. A byte accepted
//   in the input stage moves into the result register when the result slot
//   is free. One byte per cycle sustained while rsp_ch is not held off; the
//   CRC byte update is one unrolled 8-bit step. The CRC trails the input by
//   three bytes (delay line), so the CRC and end bytes never enter the sum.
// Reset: clears both stages and all frame state; registers return to
//   0xAA / 0x55. After each summary the frame state rearms on its own.
// Stall: while rsp_ch is held off the result register holds and the input
//   stage keeps its byte; req_ch.ready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   crcfr_req_if.sink   req_ch,
   crcfr_rsp_if.source rsp_ch,
   crcfr_csr_if.sink   csr_ch
);

   // configuration
   logic [7:0] start_byte_ff;
   logic [7:0] end_byte_ff;

   // input stage
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;

   // result register
   logic                       out_valid_ff, out_valid_in;
   crcfr_pkg::rsp_payload_type out_data_ff;

   logic                       req_fire;
   logic                       out_free;
   logic                       s1_adv;
   logic                       has_result;
   crcfr_pkg::rsp_payload_type result;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= crcfr_pkg::START_BYTE_RST;
         end_byte_ff   <= crcfr_pkg::END_BYTE_RST;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            crcfr_pkg::CSR_START_BYTE: start_byte_ff <= csr_ch.wdata;
            crcfr_pkg::CSR_END_BYTE:   end_byte_ff   <= csr_ch.wdata;
            default: ;
         endcase
      end
   end

   // handshake: the input stage moves on whenever the result slot is free
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign s1_adv       = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_adv);
   assign out_valid_in = out_free ? (s1_adv && has_result) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_ch.rx_byte;
         s1_last_ff <= req_ch.end_of_buffer;
      end
      if (s1_adv && has_result) begin
         out_data_ff <= result;
      end
   end

   crcfr_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .step          (s1_adv),
      .rx_byte       (s1_byte_ff),
      .end_of_buffer (s1_last_ff),
      .start_byte    (start_byte_ff),
      .end_byte      (end_byte_ff),
      .has_result    (has_result),
      .result        (result)
   );

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.is_summary     = out_data_ff.is_summary;
   assign rsp_ch.payload_byte   = out_data_ff.payload_byte;
   assign rsp_ch.status         = out_data_ff.status;
   assign rsp_ch.seq_number     = out_data_ff.seq_number;
   assign rsp_ch.command        = out_data_ff.command;
   assign rsp_ch.payload_length = out_data_ff.payload_length;

endmodule

`default_nettype wire

/* hw/rtl/crcfr_parse.sv */
// ----------------------------------------------------------------------------
// crcfr_parse: frame state and result logic
// Holds byte count, CRC, delay line and header fields; forms the result
// for the byte in the input stage.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfr_parse (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [7:0]                  rx_byte,
   input  logic                        end_of_buffer,
   input  logic [7:0]                  start_byte,
   input  logic [7:0]                  end_byte,
   output logic                        has_result,
   output crcfr_pkg::rsp_payload_type  result
);

   logic [crcfr_pkg::IdxW-1:0] idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  dl0_ff, dl1_ff, dl2_ff;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  seq_ff, seq_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [15:0] len_ff, len_in;

   logic [crcfr_pkg::IdxW-1:0] idx_sat;
   logic [crcfr_pkg::IdxW-1:0] len_ext;
   logic [crcfr_pkg::IdxW-1:0] pay_off;
   logic                       payload_hit;
   logic [2:0]                 status;

   always_comb begin
      crc_in = (idx_ff >= crcfr_pkg::POS_LEN_LO) ? crcfr_pkg::crc_feed(crc_ff, dl2_ff) : crc_ff;
      first_in = first_ff;
      seq_in   = seq_ff;
      cmd_in   = cmd_ff;
      len_in   = len_ff;
      case (idx_ff)
         crcfr_pkg::POS_START:  first_in = rx_byte;
         crcfr_pkg::POS_SEQ:    seq_in   = rx_byte;
         crcfr_pkg::POS_CMD:    cmd_in   = rx_byte;
         crcfr_pkg::POS_LEN_HI: len_in   = {rx_byte, 8'h00};
         crcfr_pkg::POS_LEN_LO: len_in   = {len_ff[15:8], rx_byte};
         default: ;
      endcase
   end

   assign idx_sat = (idx_ff != crcfr_pkg::IDX_MAX) ? idx_ff + 1'b1 : idx_ff;
   assign idx_in  = idx_sat;
   assign len_ext = {1'b0, len_in};
   assign pay_off = idx_ff - crcfr_pkg::POS_PAYLOAD;
   assign payload_hit = (idx_ff >= crcfr_pkg::POS_PAYLOAD) && (pay_off < len_ext);

   // first failing check wins
   always_comb begin
      if (idx_sat < crcfr_pkg::MIN_FRAME) begin
         status = crcfr_pkg::ST_SHORT;
      end else if (first_in != start_byte) begin
         status = crcfr_pkg::ST_BAD_START;
      end else if (rx_byte != end_byte) begin
         status = crcfr_pkg::ST_BAD_END;
      end else if (idx_sat != len_ext + crcfr_pkg::MIN_FRAME) begin
         status = crcfr_pkg::ST_LEN_ERR;
      end else if (crc_in != {dl0_ff, dl1_ff}) begin
         status = crcfr_pkg::ST_CRC_ERR;
      end else begin
         status = crcfr_pkg::ST_OK;
      end
   end

   assign has_result = end_of_buffer || payload_hit;

   always_comb begin
      result = '0;
      if (end_of_buffer) begin
         result.is_summary     = 1'b1;
         result.status         = status;
         result.seq_number     = seq_in;
         result.command        = cmd_in;
         result.payload_length = len_in;
      end else begin
         result.payload_byte = rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && end_of_buffer)) begin
         idx_ff   <= '0;
         crc_ff   <= crcfr_pkg::CRC_INIT;
         dl0_ff   <= '0;
         dl1_ff   <= '0;
         dl2_ff   <= '0;
         first_ff <= '0;
         seq_ff   <= '0;
         cmd_ff   <= '0;
         len_ff   <= '0;
      end else if (step) begin
         idx_ff   <= idx_in;
         crc_ff   <= crc_in;
         dl0_ff   <= rx_byte;
         dl1_ff   <= dl0_ff;
         dl2_ff   <= dl1_ff;
         first_ff <= first_in;
         seq_ff   <= seq_in;
         cmd_ff   <= cmd_in;
         len_ff   <= len_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/crcfr_checker.sv */
// ----------------------------------------------------------------------------
// crcfr_checker: port-level assertions
// Watches the result channel of the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_is_summary,
   input logic [7:0]  rsp_payload_byte,
   input logic [2:0]  rsp_status,
   input logic [7:0]  rsp_seq_number,
   input logic [7:0]  rsp_command,
   input logic [15:0] rsp_payload_length
);

   // stalled item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_summary)
         && $stable(rsp_payload_byte) && $stable(rsp_status)
         && $stable(rsp_payload_length))
      else $error("result changed while stalled");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_summary |-> rsp_status <= crcfr_pkg::ST_CRC_ERR)
      else $error("summary status out of range");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_summary |-> rsp_status == crcfr_pkg::ST_OK
         && rsp_seq_number == 8'h00 && rsp_command == 8'h00
         && rsp_payload_length == 16'h0000)
      else $error("payload item carries summary fields");

   a_summary_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_summary |-> rsp_payload_byte == 8'h00)
      else $error("summary item carries payload byte");

   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind crc16_frame_receiver crcfr_checker u_crcfr_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_is_summary     (rsp_ch.is_summary),
   .rsp_payload_byte   (rsp_ch.payload_byte),
   .rsp_status         (rsp_ch.status),
   .rsp_seq_number     (rsp_ch.seq_number),
   .rsp_command        (rsp_ch.command),
   .rsp_payload_length (rsp_ch.payload_length)
);

`default_nettype wire

/* bench/crc16_frame_receiver_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc16_frame_receiver_test: self-checking bench for the framed byte receiver
// Streams framed and corrupted buffers with random idling on both channels,
// predicts payload and summary items in step with the input, and compares
// every result item field by field as it is accepted.
// ----------------------------------------------------------------------------

module crc16_frame_receiver_test;

   localparam int RANDOM_ITEMS   = 920;
   localparam int LONG_HOLD      = 200;   // receiver hold-off during fill test
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
   localparam int LATENCY_PAD    = 4;     // block holds at most two items in flight

   typedef enum int {
      FR_GOOD, FR_BAD_START, FR_BAD_END, FR_LEN_ERR, FR_CRC_ERR, FR_SHORT, FR_NOISE
   } frame_kind_type;

   logic clock;
   logic reset;

   crcfr_req_if req_if ();
   crcfr_rsp_if rsp_if ();
   crcfr_csr_if csr_if ();

   crc16_frame_receiver uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // ------------------------------------------------------------------------
   // Receiver model state: register copies and per-buffer frame state
   // ------------------------------------------------------------------------
   logic [7:0]                 start_marker = crcfr_pkg::START_BYTE_RST;
   logic [7:0]                 end_marker   = crcfr_pkg::END_BYTE_RST;
   logic [crcfr_pkg::IdxW-1:0] rx_count     = '0;
   logic [15:0]                crc_run      = crcfr_pkg::CRC_INIT;
   logic [7:0]                 trail [3]    = '{8'h00, 8'h00, 8'h00};  // [0] newest byte
   logic [7:0]                 lead_byte    = '0;
   logic [7:0]                 seq_hold     = '0;
   logic [7:0]                 cmd_hold     = '0;
   logic [15:0]                len_hold     = '0;

   crcfr_pkg::rsp_payload_type pending_results [$];
   logic [7:0]                 frame_bytes [$];

   int mismatch_count = 0;
   int bytes_accepted = 0;
   int payload_seen   = 0;
   int summary_seen   = 0;
   int status_tally [6] = '{0, 0, 0, 0, 0, 0};
   int idle_cycles    = 0;

   int req_mode  = 1;    // 0 no gaps, 1 occasional gaps, 2 a gap drawn for every item
   int rsp_mode  = 1;
   bit hold_long = 1'b0; // ask the receiver for one long hold-off

   // ------------------------------------------------------------------------
   // Clock and reset
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // reflected CRC16/Modbus, one byte
   function automatic logic [15:0] modbus_crc_byte(input logic [15:0] acc,
                                                   input logic [7:0] data);
      logic [15:0] c;
      c = acc ^ 16'(data);
      repeat (8) c = c[0] ? ((c >> 1) ^ crcfr_pkg::CRC_POLY) : (c >> 1);
      return c;
   endfunction

   function automatic int draw_gap(input int mode);
      case (mode)
         0: return 0;
         1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 16)) : 0;
         default: return int'($urandom_range(0, 16));
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Predictor: one accepted byte in, zero or one expected item out.
   // The CRC sees the byte leaving the 3-deep delay line, so the two CRC
   // bytes and the end byte never enter the sum.
   // ------------------------------------------------------------------------
   task automatic track_rx_byte(input logic [7:0] b, input logic last);
      logic [crcfr_pkg::IdxW-1:0] pos;
      logic [crcfr_pkg::IdxW-1:0] total;
      crcfr_pkg::rsp_payload_type r;
      pos = rx_count;
      r   = '0;
      if (pos >= crcfr_pkg::POS_LEN_LO) crc_run = modbus_crc_byte(crc_run, trail[2]);
      case (pos)
         crcfr_pkg::POS_START:  lead_byte = b;
         crcfr_pkg::POS_SEQ:    seq_hold  = b;
         crcfr_pkg::POS_CMD:    cmd_hold  = b;
         crcfr_pkg::POS_LEN_HI: len_hold  = {b, 8'h00};
         crcfr_pkg::POS_LEN_LO: len_hold[7:0] = b;
         default: ;
      endcase

      if (last) begin
         // byte count saturates, so an overlong buffer can never match
         total = (pos == crcfr_pkg::IDX_MAX) ? crcfr_pkg::IDX_MAX : pos + 1'b1;
         r.is_summary = 1'b1;
         // first failing check wins
         if (total < crcfr_pkg::MIN_FRAME)
            r.status = crcfr_pkg::ST_SHORT;
         else if (lead_byte != start_marker)
            r.status = crcfr_pkg::ST_BAD_START;
         else if (b != end_marker)
            r.status = crcfr_pkg::ST_BAD_END;
         else if (total != crcfr_pkg::MIN_FRAME + crcfr_pkg::IdxW'(len_hold))
            r.status = crcfr_pkg::ST_LEN_ERR;
         else if (crc_run != {trail[0], trail[1]})
            r.status = crcfr_pkg::ST_CRC_ERR;
         else
            r.status = crcfr_pkg::ST_OK;
         r.seq_number     = seq_hold;
         r.command        = cmd_hold;
         r.payload_length = len_hold;
         pending_results.push_back(r);
         // rearm for the next buffer; registers keep their values
         rx_count  = '0;
         crc_run   = crcfr_pkg::CRC_INIT;
         trail     = '{8'h00, 8'h00, 8'h00};
         lead_byte = '0;
         seq_hold  = '0;
         cmd_hold  = '0;
         len_hold  = '0;
      end else begin
         trail[2] = trail[1];
         trail[1] = trail[0];
         trail[0] = b;
         if (pos != crcfr_pkg::IDX_MAX) rx_count = pos + 1'b1;
         // payload item only inside the declared length; last byte never gives one
         if (pos >= crcfr_pkg::POS_PAYLOAD
             && (pos - crcfr_pkg::POS_PAYLOAD) < crcfr_pkg::IdxW'(len_hold)) begin
            r.payload_byte = b;
            pending_results.push_back(r);
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_result();
      crcfr_pkg::rsp_payload_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("item with nothing pending, is_summary",
                         32'(rsp_if.is_summary), 32'd0);
      end else begin
         want = pending_results.pop_front();
         if (rsp_if.is_summary !== want.is_summary)
            report_mismatch("is_summary", 32'(rsp_if.is_summary), 32'(want.is_summary));
         if (rsp_if.payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", 32'(rsp_if.payload_byte),
                            32'(want.payload_byte));
         if (rsp_if.status !== want.status)
            report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
         if (rsp_if.seq_number !== want.seq_number)
            report_mismatch("seq_number", 32'(rsp_if.seq_number), 32'(want.seq_number));
         if (rsp_if.command !== want.command)
            report_mismatch("command", 32'(rsp_if.command), 32'(want.command));
         if (rsp_if.payload_length !== want.payload_length)
            report_mismatch("payload_length", 32'(rsp_if.payload_length),
                            32'(want.payload_length));
      end
      if (rsp_if.is_summary === 1'b1) begin
         summary_seen++;
         if (rsp_if.status < 3'd6) status_tally[rsp_if.status]++;
      end else begin
         payload_seen++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Monitor: all handshakes are sampled here at the rising edge. Results are
   // checked before the same edge's input byte is predicted; as the input stage
   // and result register lie between, they never match up. Also runs the watchdog.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            check_result();
            moved = 1'b1;
         end
         if (req_if.valid && req_if.ready) begin
            track_rx_byte(req_if.rx_byte, req_if.end_of_buffer);
            bytes_accepted++;
            moved = 1'b1;
         end
         if (csr_if.valid && csr_if.ready) begin
            if (csr_if.index == crcfr_pkg::CSR_START_BYTE) start_marker = csr_if.wdata;
            else if (csr_if.index == crcfr_pkg::CSR_END_BYTE) end_marker = csr_if.wdata;
            moved = 1'b1;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no handshake for %0d cycles, %0d items pending",
                     $realtime, idle_cycles, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result side: random stall before each item, one long hold on request
   // ------------------------------------------------------------------------
   initial begin : rsp_side
      int stall;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_long) begin
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_long = 1'b0;
         end else begin
            stall = draw_gap(rsp_mode);
            if (stall > 0) begin
               rsp_if.ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         @(negedge clock);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers; every task starts and ends on a falling edge
   // ------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = draw_gap(req_mode);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.rx_byte       <= b;
      req_if.end_of_buffer <= last;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // buffer in frame_bytes, end_of_buffer on its last byte
   task automatic send_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   // append CRC (low byte first) over sequence..payload, then the end byte
   task automatic seal_frame();
      logic [15:0] crc;
      crc = crcfr_pkg::CRC_INIT;
      for (int i = 1; i < frame_bytes.size(); i++) crc = modbus_crc_byte(crc, frame_bytes[i]);
      frame_bytes.push_back(crc[7:0]);
      frame_bytes.push_back(crc[15:8]);
      frame_bytes.push_back(end_marker);
   endtask

   // sender stops and waits until every predicted item is out
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
   endtask

   // register writes only with the block idle; bytes that give no item may
   // still be in the pipe after the last result, hence the pad
   task automatic set_markers(input logic [7:0] start_val, input logic [7:0] end_val);
      wait_drained();
      repeat (LATENCY_PAD) @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= crcfr_pkg::CSR_START_BYTE;
      csr_if.wdata <= start_val;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.index <= crcfr_pkg::CSR_END_BYTE;
      csr_if.wdata <= end_val;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   function automatic frame_kind_type pick_kind();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll <= 10) return FR_GOOD;
      if (roll == 11) return FR_BAD_START;
      if (roll == 12) return FR_BAD_END;
      if (roll <= 14) return FR_LEN_ERR;
      if (roll <= 16) return FR_CRC_ERR;
      if (roll == 17) return FR_SHORT;
      return FR_NOISE;
   endfunction

   // well-formed frame with random content, then the chosen damage
   task automatic build_random_frame(input frame_kind_type kind);
      int plen;
      int pick;
      int cut;
      plen = ($urandom_range(0, 7) == 0) ? int'($urandom_range(13, 48))
                                         : int'($urandom_range(0, 12));
      frame_bytes = '{start_marker, 8'($urandom), 8'($urandom), 8'(plen >> 8), 8'(plen)};
      repeat (plen) frame_bytes.push_back(8'($urandom));
      seal_frame();
      case (kind)
         FR_BAD_START: frame_bytes[0] ^= 8'($urandom_range(1, 255));
         FR_BAD_END:   frame_bytes[frame_bytes.size() - 1] ^= 8'($urandom_range(1, 255));
         FR_LEN_ERR: begin
            // either an extra byte or a wrong declared length
            if ($urandom_range(0, 1)) frame_bytes.insert(5, 8'($urandom));
            else frame_bytes[4] ^= 8'($urandom_range(1, 255));
         end
         FR_CRC_ERR: begin
            // single bit flip in payload or CRC bytes
            pick = $urandom_range(5, frame_bytes.size() - 2);
            frame_bytes[pick] ^= 8'(1 << $urandom_range(0, 7));
         end
         FR_SHORT: begin
            cut = $urandom_range(1, 7);
            while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
         end
         FR_NOISE: begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 24)) frame_bytes.push_back(8'($urandom));
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // header extremes, short buffers, a good frame, a buffer cut off in payload
   task automatic test_directed_frames();
      req_mode = 1;
      rsp_mode = 1;
      // single byte: short, nothing of the header captured
      frame_bytes = '{8'h00};
      send_frame();
      // header cut after command: short, seq and command reported, length 0
      frame_bytes = '{start_marker, 8'hFF, 8'h00};
      send_frame();
      // good frame, one payload byte of all ones
      frame_bytes = '{start_marker, 8'hFF, 8'h00, 8'h00, 8'h01, 8'hFF};
      seal_frame();
      send_frame();
      // largest declared length, buffer ends inside the payload: two payload
      // items, the last byte gives the summary only
      frame_bytes = '{start_marker, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h5A, end_marker};
      send_frame();
   endtask

   // receiver holds off long enough for the block to fill and stall input
   task automatic test_backpressure();
      req_mode = 0;
      rsp_mode = 0;
      frame_bytes = '{start_marker, 8'h11, 8'h22, 8'h00, 8'd40};
      repeat (40) frame_bytes.push_back(8'($urandom));
      seal_frame();
      hold_long = 1'b1;
      send_frame();
      wait_drained();
   endtask

   // mostly well-formed frames under several marker settings, idling mixed
   task automatic test_random_frames();
      int sent;
      sent = 0;
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: set_markers(8'h00, 8'hFF);
            1: set_markers(8'hFF, 8'h00);
            2: set_markers(8'h7E, 8'h7E);     // same marker at both ends
            3: set_markers(8'($urandom), 8'($urandom));
            default: set_markers(crcfr_pkg::START_BYTE_RST, crcfr_pkg::END_BYTE_RST);
         endcase
         while (sent < (ph + 1) * RANDOM_ITEMS / 5) begin
            req_mode = $urandom_range(0, 2);
            rsp_mode = $urandom_range(0, 2);
            build_random_frame(pick_kind());
            send_frame();
            sent += frame_bytes.size();
            if ($urandom_range(0, 11) == 0) wait_drained();
         end
      end
   endtask

   // overlong buffer: payload items stop at the declared length and the
   // summary reports a length mismatch
   task automatic test_overlong_buffer();
      req_mode = 0;
      rsp_mode = 1;
      set_markers(crcfr_pkg::START_BYTE_RST, crcfr_pkg::END_BYTE_RST);
      frame_bytes = '{start_marker, 8'hA5, 8'h3C, 8'h00, 8'h04};
      repeat (60) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(end_marker);
      send_frame();
      wait_drained();
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.rx_byte       = '0;
      req_if.end_of_buffer = 1'b0;
      csr_if.valid         = 1'b0;
      csr_if.index         = crcfr_pkg::CSR_START_BYTE;
      csr_if.wdata         = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_frames();
      test_backpressure();
      test_random_frames();
      test_overlong_buffer();

      wait_drained();
      repeat (LATENCY_PAD * 2) @(negedge clock);
      if (pending_results.size() != 0)
         report_mismatch("items never delivered", 32'd0, 32'(pending_results.size()));

      $display("Run: %0d bytes in, %0d payload items and %0d summaries checked",
               bytes_accepted, payload_seen, summary_seen);
      $display("Summaries ok/short/start/end/length/crc: %0d/%0d/%0d/%0d/%0d/%0d",
               status_tally[crcfr_pkg::ST_OK], status_tally[crcfr_pkg::ST_SHORT],
               status_tally[crcfr_pkg::ST_BAD_START], status_tally[crcfr_pkg::ST_BAD_END],
               status_tally[crcfr_pkg::ST_LEN_ERR], status_tally[crcfr_pkg::ST_CRC_ERR]);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/crcfr_pkg.sv
hw/rtl/crcfr_if.sv
hw/rtl/crcfr_parse.sv
hw/rtl/crc16_frame_receiver.sv
hw/rtl/crcfr_checker.sv
bench/crc16_frame_receiver_test.sv
